FILE: rtl/cfp_pkg.sv
package cfp_pkg;

  localparam logic [7:0] START_BYTE  = 8'hA5;
  localparam int         STORE_DEPTH = 16;
  localparam int         IDX_W       = 4;
  localparam int         WORD_W      = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic sum_init;    // restart the sum from the start byte (or zero)
    logic sum_add;     // add the current byte to the running sum
    logic len_load;    // take the length byte as word count
    logic lo_latch;    // hold the low byte of a data word
    logic word_write;  // write the completed word into the store
    logic chk_latch;   // hold the low byte of the received checksum
    logic emit_start;  // rewind the read pointer
    logic emit_step;   // move the next stored word into the output register
  } cfp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_start;    // current byte is the start byte
    logic len_ok;      // current byte is a usable length
    logic rem_zero;    // no data words left to read
    logic chk_match;   // received checksum equals the expected one
    logic emit_done;   // last word of the frame loads this cycle
  } cfp_status_t;

endpackage

FILE: rtl/cfp_ctrl.sv
module cfp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfp_pkg::cfp_status_t status,
  output cfp_pkg::cfp_cmd_t    cmd
);
  import cfp_pkg::*;

  typedef enum logic [2:0] {
    HUNT,
    LEN,
    DLO,
    DHI,
    CSLO,
    CSHI,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      HUNT: begin
        if (accept) begin
          cmd.sum_init = 1'b1;
          if (status.is_start) begin
            state_next = LEN;
          end
        end
      end
      LEN: begin
        if (accept) begin
          cmd.sum_add = 1'b1;
          if (status.len_ok) begin
            cmd.len_load = 1'b1;
            state_next   = DLO;
          end else begin
            state_next = HUNT;
          end
        end
      end
      DLO: begin
        if (accept) begin
          cmd.sum_add  = 1'b1;
          cmd.lo_latch = 1'b1;
          state_next   = DHI;
        end
      end
      DHI: begin
        if (accept) begin
          cmd.sum_add    = 1'b1;
          cmd.word_write = 1'b1;
          state_next     = status.rem_zero ? CSLO : DLO;
        end
      end
      CSLO: begin
        if (accept) begin
          cmd.chk_latch = 1'b1;
          state_next    = CSHI;
        end
      end
      CSHI: begin
        if (accept) begin
          if (status.chk_match) begin
            cmd.emit_start = 1'b1;
            state_next     = EMIT;
          end else begin
            state_next = HUNT;
          end
        end
      end
      EMIT: begin
        cmd.emit_step = 1'b1;
        if (status.emit_done) begin
          state_next = HUNT;
        end
      end
      default: begin
        state_next = HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= HUNT;
      in_stall <= 1'b0;
    end else begin
      state    <= state_next;
      in_stall <= (state_next == EMIT);
    end
  end

endmodule

FILE: rtl/cfp_datapath.sv
module cfp_datapath #(
  parameter int MAX_WORDS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        byte_in,
  input  cfp_pkg::cfp_cmd_t                 cmd,
  output cfp_pkg::cfp_status_t              status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cfp_pkg::IDX_W-1:0]         word_index,
  output logic [cfp_pkg::WORD_W-1:0]        cell_word,
  output logic                              last_word
);
  import cfp_pkg::*;

  localparam int FW = $clog2(MAX_WORDS + 1);
  localparam int CW = (FW > 5) ? FW : 5;

  logic [WORD_W-1:0] word_store [STORE_DEPTH];

  logic [FW-1:0]     remaining_words;
  logic [FW-1:0]     frame_words;
  logic [IDX_W-1:0]  write_index;
  logic [7:0]        low_byte_latch;
  logic [15:0]       running_sum;
  logic [7:0]        received_check_low;
  logic [IDX_W-1:0]  read_index;

  logic [CW-1:0]     frame_words_ext;
  logic [IDX_W-1:0]  last_index;
  logic              out_free;

  assign frame_words_ext = CW'(frame_words);
  // clip the emitted count to the store depth
  assign last_index = (frame_words_ext > CW'(STORE_DEPTH)) ? IDX_W'(STORE_DEPTH - 1)
                                                           : IDX_W'(frame_words_ext - 1'b1);
  assign out_free   = !out_valid || !out_stall;

  assign status.is_start  = (byte_in == START_BYTE);
  assign status.len_ok    = (byte_in != 8'd0) && (byte_in <= 8'(MAX_WORDS));
  assign status.rem_zero  = (remaining_words == '0);
  assign status.chk_match = ({byte_in, received_check_low} == ~running_sum);
  assign status.emit_done = out_free && (read_index == last_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_words <= '0;
      frame_words     <= '0;
      write_index     <= '0;
      running_sum     <= '0;
      read_index      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.sum_init) begin
        running_sum <= status.is_start ? 16'(START_BYTE) : 16'd0;
      end else if (cmd.sum_add) begin
        running_sum <= running_sum + 16'(byte_in);
      end
      if (cmd.len_load) begin
        remaining_words <= FW'(byte_in);
        frame_words     <= FW'(byte_in);
        write_index     <= '0;
      end
      if (cmd.lo_latch && (remaining_words != '0)) begin
        remaining_words <= remaining_words - 1'b1;
      end
      if (cmd.word_write) begin
        write_index <= write_index + 1'b1;
      end
      if (cmd.emit_start) begin
        read_index <= '0;
      end
      if (cmd.emit_step && out_free) begin
        out_valid  <= 1'b1;
        read_index <= read_index + 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // store and registered read; the read register is the output register
  always_ff @(posedge clk) begin
    if (cmd.lo_latch) begin
      low_byte_latch <= byte_in;
    end
    if (cmd.chk_latch) begin
      received_check_low <= byte_in;
    end
    if (cmd.word_write) begin
      word_store[write_index] <= {byte_in, low_byte_latch};
    end
    if (cmd.emit_step && out_free) begin
      cell_word  <= word_store[read_index];
      word_index <= read_index;
      last_word  <= (read_index == last_index);
    end
  end

endmodule

FILE: rtl/cell_frame_parser.sv
// Frame parser for a byte stream from a slow serial link. Hunt for the start
// byte 0xA5, then take a length byte: 1 to MAX_WORDS words are accepted, any
// other length drops the frame and hunting resumes with the next byte. Then
// read that many 16-bit words, low byte first, into a 16-entry store,
// followed by a 16-bit checksum, low byte first. The expected checksum is
// 0xFFFF minus the 16-bit wrapping sum of every byte from the start byte up to
// the last data byte. On a match each stored word is delivered as one request
// carrying its index and a last flag; on a mismatch nothing is delivered.
// Frames longer than 16 words wrap in the store: later words overwrite
// earlier ones and only store entries 0..15 are delivered.
// Rate: bytes are taken back to back whenever the input is not stalled. After
// the final checksum byte of a good frame the input is stalled while the store
// is read out through its single read port, one word per cycle while the output
// is not stalled.
// The output is registered, so the last word may still wait on the output
// while the next frame is already being received.
module cell_frame_parser #(
  parameter int MAX_WORDS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                byte_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [cfp_pkg::IDX_W-1:0] word_index,
  output logic [cfp_pkg::WORD_W-1:0] cell_word,
  output logic                      last_word
);
  import cfp_pkg::*;

  cfp_cmd_t    cmd;
  cfp_status_t status;

  // sequence the frame fields and the read-out
  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // sum, counters, word store and output register
  cfp_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .cell_word  (cell_word),
    .last_word  (last_word)
  );

  // leaving read-out always leaves the final word waiting on the output
  a_release_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid && last_word)
    else $error("input released without the last word on the output");

  // a word that is not the last only appears while read-out holds the input
  a_mid_frame_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_word |-> in_stall)
    else $error("non-final word on the output outside read-out");

  // once a non-final word is taken the next index follows at once
  a_next_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && (word_index == IDX_W'($past(word_index) + 1'b1)))
    else $error("read-out did not advance to the next word");

endmodule

FILE: test/tb_cell_frame_parser.sv
`timescale 1ns / 100ps

module tb_cell_frame_parser;
  import cfp_pkg::*;

  localparam int MAX_WORDS   = 16;
  localparam int STALL_LIMIT = 5000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES = 300;   // long output hold-off that forces the input to stall
  localparam int N_DIRECTED  = 26;

  // Parser states as the predictor tracks them
  typedef enum logic [2:0] {
    PS_HUNT, PS_LEN, PS_DATA_LO, PS_DATA_HI, PS_SUM_LO, PS_SUM_HI
  } parse_phase_t;

  // How a directed row gets its expectation
  typedef enum logic [1:0] {
    EXP_MODEL,  // predictor decides
    EXP_NONE,   // no word may come from this byte
    EXP_WORD    // exactly one word, index 0, flagged last
  } exp_kind_t;

  typedef struct {
    logic [7:0]        data;
    exp_kind_t         kind;
    logic [WORD_W-1:0] word;
  } directed_row_t;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              last;
  } word_req_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        byte_in;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] cell_word;
  logic              last_word;

  cell_frame_parser #(.MAX_WORDS(MAX_WORDS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_in    (byte_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .cell_word  (cell_word),
    .last_word  (last_word)
  );

  always #1 clk = ~clk;

  // Predictor state: a private copy of the parser, advanced once per byte offered
  parse_phase_t      phase      = PS_HUNT;
  logic [4:0]        words_left = '0;
  logic [4:0]        frame_len  = '0;
  logic [IDX_W-1:0]  wr_ptr     = '0;
  logic [7:0]        lo_byte    = '0;
  logic [15:0]       byte_sum   = '0;
  logic [7:0]        sum_lo     = '0;
  logic [WORD_W-1:0] frame_store [STORE_DEPTH];

  word_req_t   pending_words [$];  // words still owed by the block, oldest first
  logic [7:0]  frame_bytes [$];    // byte stream of the frame being built

  int send_gap_pct = 0;
  int stall_pct    = 0;
  bit hold_req     = 1'b0;
  int quiet_cycles = 0;
  int mismatches   = 0;
  int words_seen   = 0;
  int bytes_sent   = 0;
  int good_frames  = 0;

  // Directed bytes: idle-line noise, bad lengths, the length byte that looks like
  // a start byte, a one-word frame at the word extreme, a zero word left to the
  // predictor, and a frame whose checksum is wrong.
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, EXP_NONE,  16'h0000},
    '{8'hFF, EXP_NONE,  16'h0000},
    '{8'hA5, EXP_NONE,  16'h0000},
    '{8'h00, EXP_NONE,  16'h0000},   // length zero: drop
    '{8'hA5, EXP_NONE,  16'h0000},
    '{8'h11, EXP_NONE,  16'h0000},   // one word too many: drop
    '{8'hA5, EXP_NONE,  16'h0000},
    '{8'hA5, EXP_NONE,  16'h0000},   // taken as a length, not a fresh start
    '{8'hA5, EXP_NONE,  16'h0000},
    '{8'h01, EXP_NONE,  16'h0000},
    '{8'hFF, EXP_NONE,  16'h0000},
    '{8'hFF, EXP_NONE,  16'h0000},
    '{8'h5B, EXP_NONE,  16'h0000},
    '{8'hFD, EXP_WORD,  16'hFFFF},   // checksum 0xFD5B matches
    '{8'hA5, EXP_MODEL, 16'h0000},
    '{8'h01, EXP_MODEL, 16'h0000},
    '{8'h00, EXP_MODEL, 16'h0000},
    '{8'h00, EXP_MODEL, 16'h0000},
    '{8'h59, EXP_MODEL, 16'h0000},
    '{8'hFF, EXP_MODEL, 16'h0000},
    '{8'hA5, EXP_NONE,  16'h0000},
    '{8'h01, EXP_NONE,  16'h0000},
    '{8'h34, EXP_NONE,  16'h0000},
    '{8'h12, EXP_NONE,  16'h0000},
    '{8'h00, EXP_NONE,  16'h0000},
    '{8'h00, EXP_NONE,  16'h0000}    // wrong checksum: nothing comes out
  };

  // Advance the parser copy by one byte and queue the words a good frame releases.
  // Return 0 only for a byte ignored while hunting.
  function automatic bit decode_byte(input logic [7:0] b);
    int n;
    decode_byte = 1'b1;
    case (phase)
      PS_HUNT: begin
        byte_sum = '0;
        if (b == START_BYTE) begin
          byte_sum = 16'(b);
          phase    = PS_LEN;
        end else begin
          decode_byte = 1'b0;
        end
      end
      PS_LEN: begin
        byte_sum = byte_sum + 16'(b);
        if (b >= 1 && b <= MAX_WORDS) begin
          words_left = b[4:0];
          frame_len  = b[4:0];
          wr_ptr     = '0;
          phase      = PS_DATA_LO;
        end else begin
          phase = PS_HUNT;
        end
      end
      PS_DATA_LO: begin
        byte_sum = byte_sum + 16'(b);
        lo_byte  = b;
        if (words_left != 0) words_left = words_left - 1'b1;
        phase = PS_DATA_HI;
      end
      PS_DATA_HI: begin
        byte_sum = byte_sum + 16'(b);
        frame_store[wr_ptr] = {b, lo_byte};
        wr_ptr = wr_ptr + 1'b1;
        phase  = (words_left == 0) ? PS_SUM_LO : PS_DATA_LO;
      end
      PS_SUM_LO: begin
        sum_lo = b;
        phase  = PS_SUM_HI;
      end
      PS_SUM_HI: begin
        if ({b, sum_lo} == 16'hFFFF - byte_sum) begin
          n = (frame_len > STORE_DEPTH) ? STORE_DEPTH : int'(frame_len);
          good_frames++;
          for (int k = 0; k < n; k++)
            pending_words.push_back(word_req_t'{idx: IDX_W'(k), word: frame_store[k],
                                                last: (k == n - 1)});
        end
        phase = PS_HUNT;
      end
      default: phase = PS_HUNT;
    endcase
  endfunction

  // Offer one byte as a request. Update the expectations at the falling edge,
  // well clear of the rising edge at which results are checked.
  task automatic send_byte(input logic [7:0] b, input exp_kind_t kind,
                           input logic [WORD_W-1:0] typed_word, output bit taken);
    int queued;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    queued = pending_words.size();
    taken  = decode_byte(b);
    if (kind != EXP_MODEL) begin
      // typed rows replace whatever the predictor queued for this byte
      while (pending_words.size() > queued) void'(pending_words.pop_back());
      if (kind == EXP_WORD)
        pending_words.push_back(word_req_t'{idx: '0, word: typed_word, last: 1'b1});
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       rand_byte = 8'h00;
      1:       rand_byte = 8'hFF;
      default: rand_byte = 8'($urandom_range(255));
    endcase
  endfunction

  // Append one complete frame; spoil the checksum if asked.
  task automatic make_frame(input int len, input bit bad_sum);
    logic [15:0] sum;
    logic [7:0]  d;
    frame_bytes.push_back(START_BYTE);
    frame_bytes.push_back(8'(len));
    sum = 16'(START_BYTE) + 16'(len);
    for (int i = 0; i < 2 * len; i++) begin
      d = rand_byte();
      frame_bytes.push_back(d);
      sum = sum + 16'(d);
    end
    sum = 16'hFFFF - sum;
    if (bad_sum) sum = sum ^ 16'($urandom_range(1, 65535));
    frame_bytes.push_back(sum[7:0]);
    frame_bytes.push_back(sum[15:8]);
  endtask

  // Mostly well-formed frames of small size, with full-size ones, spoilt
  // checksums, illegal lengths, line noise and frames cut short mixed in.
  task automatic build_frame();
    int pick, len;
    frame_bytes.delete();
    pick = $urandom_range(99);
    case ($urandom_range(19))
      0, 1, 2:                       len = MAX_WORDS;
      3, 4, 5, 6, 7:                 len = $urandom_range(4, MAX_WORDS - 1);
      default:                       len = $urandom_range(1, 3);
    endcase
    if (pick < 62) begin
      make_frame(len, 1'b0);
    end else if (pick < 72) begin
      make_frame(len, 1'b1);
    end else if (pick < 80) begin
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back($urandom_range(1) ? 8'h00 : 8'($urandom_range(MAX_WORDS + 1, 255)));
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(255)));
    end else begin
      // cut short: whatever follows is swallowed as data or checksum
      frame_bytes.push_back(START_BYTE);
      frame_bytes.push_back(8'(len));
      repeat ($urandom_range(0, 2 * len)) frame_bytes.push_back(rand_byte());
    end
  endtask

  // Run random traffic under one idling profile until enough bytes have been parsed.
  task automatic run_phase(input int gap_pct, input int hold_pct, input int budget);
    int counted;
    bit taken;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    counted      = 0;
    while (counted < budget) begin
      build_frame();
      foreach (frame_bytes[i]) begin
        send_byte(frame_bytes[i], EXP_MODEL, '0, taken);
        if (taken) counted++;
      end
    end
  endtask

  // Output side: stall at random, or hold off for a long stretch on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Check every delivered word against the oldest expectation; count quiet cycles.
  always @(posedge clk) begin : check_words
    word_req_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        words_seen++;
        if (pending_words.size() == 0) begin
          $error("unexpected word: word_index %0d cell_word %h last_word %b",
                 word_index, cell_word, last_word);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (word_index !== want.idx) begin
            $error("word_index: expected %0d, actual %0d", want.idx, word_index);
            mismatches++;
          end
          if (cell_word !== want.word) begin
            $error("cell_word: expected %h, actual %h", want.word, cell_word);
            mismatches++;
          end
          if (last_word !== want.last) begin
            $error("last_word: expected %b, actual %b", want.last, last_word);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: give up once nothing has moved for too long.
  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    bit taken;
    rst      = 1'b1;
    in_valid = 1'b0;
    byte_in  = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed bytes, back to back
    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(directed_rows[i].data, directed_rows[i].kind, directed_rows[i].word, taken);

    // Random traffic under each idling profile
    run_phase(0, 0, 55);
    run_phase(86, 0, 55);
    run_phase(0, 86, 55);
    run_phase(25, 25, 55);

    // Back-pressure: hold the output off while two full frames are offered,
    // so the read-out backs up and the input has to stall.
    send_gap_pct = 0;
    stall_pct    = 0;
    frame_bytes.delete();
    make_frame(MAX_WORDS, 1'b0);
    make_frame(MAX_WORDS, 1'b0);
    hold_req = 1'b1;
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], EXP_MODEL, '0, taken);

    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    wait (pending_words.size() == 0);
    // drain: let any stray words show themselves
    repeat (40) @(posedge clk);

    $display("Sent %0d bytes: directed cases, four idling profiles and a long output hold-off.",
             bytes_sent);
    $display("%0d frames passed their checksum; %0d words checked, %0d mismatches.",
             good_frames, words_seen, mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/cfp_pkg.sv
rtl/cfp_ctrl.sv
rtl/cfp_datapath.sv
rtl/cell_frame_parser.sv
test/tb_cell_frame_parser.sv
